// ----- sv/gbs_pkg.sv -----
// ----------------------------------------------------------------------------
// gbs_pkg: shared constants for the Gaussian background subtraction block
// Store geometry, field widths, configuration register indexes and limits.
// ----------------------------------------------------------------------------
package gbs_pkg;

  localparam int ADDR_W = 19;
  localparam int FP_W   = 20;
  localparam int SUM_W  = 16;
  localparam int DEV_W  = 24;
  localparam int N_W    = 8;
  localparam int PIX_W  = 8;
  localparam int WGT_W  = 12;
  localparam int PH_W   = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [FP_W-1:0]  MAX_PIXELS   = FP_W'(524288);
  localparam logic [PH_W-1:0]  DETECT_PHASE = PH_W'(256);
  localparam logic [DEV_W-1:0] DEV_MAX      = {DEV_W{1'b1}};
  localparam logic [PIX_W-1:0] MEAN_MAX     = {PIX_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PIXELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAIN_FRAMES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_Q4    = 2'd2;

  localparam logic [FP_W-1:0]  RST_FRAME_PIXELS = FP_W'(307200);
  localparam logic [N_W-1:0]   RST_TRAIN_FRAMES = N_W'(200);
  localparam logic [WGT_W-1:0] RST_WEIGHT_Q4    = WGT_W'(32);

endpackage

// ----- sv/gbs_div.sv -----
// ----------------------------------------------------------------------------
// gbs_div: radix-2 restoring divider
// Divides the per-pixel sum by the frame count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gbs_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [gbs_pkg::SUM_W-1:0] dividend,
  input  logic [gbs_pkg::N_W-1:0]   divisor,
  output logic                     done,
  output logic [gbs_pkg::SUM_W-1:0] quotient
);
  import gbs_pkg::*;

  localparam int CNT_W = $clog2(SUM_W);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [N_W-1:0]   rem;
  logic [N_W-1:0]   dvs;
  logic [SUM_W-1:0] quo;
  logic [N_W:0]     trial;
  logic             fits;

  assign trial    = {rem, quo[SUM_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        rem   <= '0;
        dvs   <= divisor;
        quo   <= dividend;
      end else if (busy) begin
        if (fits) begin
          rem <= N_W'(trial - {1'b0, dvs});
          quo <= {quo[SUM_W-2:0], 1'b1};
        end else begin
          rem <= trial[N_W-1:0];
          quo <= {quo[SUM_W-2:0], 1'b0};
        end
        count <= count + 1'b1;
        if (count == CNT_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- sv/gaussian_background_subtraction_top.sv -----
// ----------------------------------------------------------------------------
// gaussian_background_subtraction_top: single-Gaussian background subtraction
// Per-pixel sum and sum of squares over training frames, mean and deviation
// sum in a model frame, then one foreground flag per pixel.
// ----------------------------------------------------------------------------
// One pixel at a time; the two stores have a registered read.
// Training pixel: read, then write back.
// Model-frame pixel: read, the 16-step divider, two multiply steps, then write back.
// Detection pixel: read, difference multiply, then the output register; the
// output register is one transaction deep.
// Reset sets the configuration registers to their defaults; the stores are not cleared.
module gaussian_background_subtraction_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wen,
  input  logic [gbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gbs_pkg::FP_W-1:0]      cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [gbs_pkg::PIX_W-1:0]     pixel,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         foreground,
  output logic                         frame_end
);
  import gbs_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_READ = 8'b0000_0010,
    S_DIV  = 8'b0000_0100,
    S_MUL1 = 8'b0000_1000,
    S_MUL2 = 8'b0001_0000,
    S_DEV  = 8'b0010_0000,
    S_DMUL = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  state_t state;

  logic [FP_W-1:0]  frame_pixels;
  logic [N_W-1:0]   train_frames;
  logic [WGT_W-1:0] weight_q4;
  logic [PH_W-1:0]  frame_phase;
  logic [ADDR_W-1:0] pixel_index;

  logic [SUM_W-1:0] sum_mem [MAX_PIXELS];
  logic [DEV_W-1:0] dev_mem [MAX_PIXELS];
  logic [SUM_W-1:0] rd_s;
  logic [DEV_W-1:0] rd_q;

  logic [N_W-1:0]    n_eff;
  logic [FP_W-1:0]   fp_eff;
  logic [FP_W-1:0]   idx_wide;
  logic              last;
  logic              is_train;
  logic              accept;

  logic [ADDR_W-1:0] addr;
  logic [PIX_W-1:0]  px;
  logic [SUM_W-1:0]  sq;
  logic              first;
  logic              train;
  logic              detect;
  logic              last_reg;

  logic [SUM_W-1:0]  s_reg;
  logic [DEV_W-1:0]  q_reg;
  logic [PIX_W-1:0]  m_reg;
  logic [DEV_W-1:0]  ms;
  logic [SUM_W-1:0]  mm;
  logic [DEV_W-1:0]  nmm;
  logic [SUM_W-1:0]  d_reg;
  logic [DEV_W+1:0]  lhs;
  logic [WGT_W+DEV_W-1:0] rhs;

  logic              div_start;
  logic              div_done;
  logic [SUM_W-1:0]  div_quo;

  logic [SUM_W:0]    s_add;
  logic [DEV_W:0]    q_add;
  logic signed [DEV_W+2:0] dev_wide;
  logic [SUM_W-1:0]  wr_s;
  logic [DEV_W-1:0]  wr_q;
  logic              wr_en;
  logic              emit_ok;

  assign n_eff  = (train_frames == '0) ? N_W'(1) : train_frames;
  assign fp_eff = (frame_pixels == '0) ? FP_W'(1) :
                  (frame_pixels > MAX_PIXELS) ? MAX_PIXELS : frame_pixels;
  assign idx_wide = ({1'b0, pixel_index} >= fp_eff) ? fp_eff - 1'b1 : {1'b0, pixel_index};
  assign last     = (idx_wide + 1'b1) >= fp_eff;
  assign is_train = frame_phase < {1'b0, n_eff};

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign emit_ok  = !out_valid || out_ready;

  assign div_start = (state == S_READ) && !train && !detect;

  assign s_add = {1'b0, rd_s} + {{(SUM_W-PIX_W+1){1'b0}}, px};
  assign q_add = {1'b0, rd_q} + {{(DEV_W-SUM_W+1){1'b0}}, sq};
  assign dev_wide = $signed({3'b000, q_reg}) + $signed({3'b000, nmm})
                  - $signed({2'b00, ms, 1'b0});

  always_comb begin
    wr_en = 1'b0;
    wr_s  = s_reg;
    wr_q  = q_reg;
    if (state == S_READ && train) begin
      wr_en = 1'b1;
      if (first) begin
        wr_s = {{(SUM_W-PIX_W){1'b0}}, px};
        wr_q = {{(DEV_W-SUM_W){1'b0}}, sq};
      end else begin
        wr_s = s_add[SUM_W] ? {SUM_W{1'b1}} : s_add[SUM_W-1:0];
        wr_q = q_add[DEV_W] ? DEV_MAX : q_add[DEV_W-1:0];
      end
    end else if (state == S_DEV) begin
      wr_en = 1'b1;
      wr_s  = {{(SUM_W-PIX_W){1'b0}}, m_reg};
      if (dev_wide < 0) begin
        wr_q = '0;
      end else if (dev_wide > $signed({3'b000, DEV_MAX})) begin
        wr_q = DEV_MAX;
      end else begin
        wr_q = dev_wide[DEV_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sum_mem[addr] <= wr_s;
    end
    if (accept) begin
      rd_s <= sum_mem[idx_wide[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      dev_mem[addr] <= wr_q;
    end
    if (accept) begin
      rd_q <= dev_mem[idx_wide[ADDR_W-1:0]];
    end
  end

  gbs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rd_s),
    .divisor  (n_eff),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pixels <= RST_FRAME_PIXELS;
      train_frames <= RST_TRAIN_FRAMES;
      weight_q4    <= RST_WEIGHT_Q4;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_FRAME_PIXELS: frame_pixels <= cfg_data;
        CFG_TRAIN_FRAMES: train_frames <= cfg_data[N_W-1:0];
        CFG_WEIGHT_Q4:    weight_q4    <= cfg_data[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      frame_phase <= '0;
      pixel_index <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            addr     <= idx_wide[ADDR_W-1:0];
            px       <= pixel;
            sq       <= {{PIX_W{1'b0}}, pixel} * {{PIX_W{1'b0}}, pixel};
            first    <= (frame_phase == '0);
            train    <= is_train;
            detect   <= frame_phase[PH_W-1];
            last_reg <= last;
            if (last) begin
              pixel_index <= '0;
              frame_phase <= is_train ? frame_phase + 1'b1 : DETECT_PHASE;
            end else begin
              pixel_index <= ADDR_W'(idx_wide + 1'b1);
            end
            state <= S_READ;
          end
        end
        S_READ: begin
          s_reg <= rd_s;
          q_reg <= rd_q;
          d_reg <= ({{PIX_W{1'b0}}, px} > rd_s) ? {{PIX_W{1'b0}}, px} - rd_s
                                               : rd_s - {{PIX_W{1'b0}}, px};
          if (train) begin
            state <= S_IDLE;
          end else if (detect) begin
            state <= S_DMUL;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            m_reg <= (div_quo[SUM_W-1:PIX_W] != '0) ? MEAN_MAX : div_quo[PIX_W-1:0];
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          ms    <= {{SUM_W{1'b0}}, m_reg} * {{PIX_W{1'b0}}, s_reg};
          mm    <= {{PIX_W{1'b0}}, m_reg} * {{PIX_W{1'b0}}, m_reg};
          state <= S_MUL2;
        end
        S_MUL2: begin
          nmm   <= {{SUM_W{1'b0}}, n_eff} * {{PIX_W{1'b0}}, mm};
          state <= S_DEV;
        end
        S_DEV: begin
          state <= S_IDLE;
        end
        S_DMUL: begin
          lhs   <= {{(DEV_W+2-SUM_W){1'b0}}, d_reg} * {{(DEV_W+2-N_W){1'b0}}, n_eff};
          rhs   <= {{DEV_W{1'b0}}, weight_q4} * {{WGT_W{1'b0}}, q_reg};
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_ok) begin
            out_valid  <= 1'b1;
            foreground <= {{(WGT_W-6){1'b0}}, lhs, 4'b0000} > rhs;
            frame_end  <= last_reg;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("Divider finished outside the divide step.");

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_READ)
    else $error("Accepted transaction did not move to the read step.");

  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    (accept && last) |=> pixel_index == '0)
    else $error("Pixel index did not wrap after the last pixel of a frame.");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    frame_phase[PH_W-1] |-> frame_phase[PH_W-2:0] == '0)
    else $error("Frame phase went past the detection code.");

endmodule

// ----- test/gaussian_background_subtraction_top_test.sv -----
// ----------------------------------------------------------------------------
// gaussian_background_subtraction_top_test: testbench for background subtraction
// Trains the per-pixel background on a small frame, builds the mean and deviation
// model with the frame count changed halfway, then checks every foreground flag
// and frame end against a predictor, under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module gaussian_background_subtraction_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gbs_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 32;
  localparam int TRAIN_PIXELS  = 32;
  localparam int STORE_DEPTH   = int'(MAX_PIXELS);
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic foreground;
    logic frame_end;
  } verdict_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_wen   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FP_W-1:0]      cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [PIX_W-1:0]     pixel     = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 foreground;
  logic                 frame_end;

  logic [FP_W-1:0]  cur_frame_pixels = RST_FRAME_PIXELS;
  logic [N_W-1:0]   cur_train_frames = RST_TRAIN_FRAMES;
  logic [WGT_W-1:0] cur_weight       = RST_WEIGHT_Q4;
  int unsigned      phase_count      = 0;
  int unsigned      next_index       = 0;
  bit [SUM_W-1:0]   sum_mean   [STORE_DEPTH];
  bit [DEV_W-1:0]   square_dev [STORE_DEPTH];
  verdict_t         expected_verdicts [$];

  bit [PIX_W-1:0]   base_level [TRAIN_PIXELS];
  int               spread     [TRAIN_PIXELS];

  int unsigned flag_errors = 0;
  int          burst_left  = 0;
  int          ready_left  = 0;
  int          cycle_count = 0;

  gaussian_background_subtraction_top u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel      (pixel),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .foreground (foreground),
    .frame_end  (frame_end)
  );

  always #6 clk = ~clk;

  function automatic int unsigned frames_used();
    return (cur_train_frames == 0) ? 1 : int'(cur_train_frames);
  endfunction

  function automatic int unsigned pixels_used();
    if (cur_frame_pixels == 0) return 1;
    if (cur_frame_pixels > MAX_PIXELS) return STORE_DEPTH;
    return int'(cur_frame_pixels);
  endfunction

  function automatic int unsigned current_position();
    int unsigned fp;
    fp = pixels_used();
    return (next_index >= fp) ? fp - 1 : next_index;
  endfunction

  task automatic classify_pixel(input logic [PIX_W-1:0] px);
    int unsigned n;
    int unsigned fp;
    int unsigned idx;
    longint      pv;
    longint      s;
    longint      q;
    longint      m;
    longint      dev;
    longint      d;
    bit          last;
    verdict_t    v;
    n = frames_used();
    fp = pixels_used();
    idx = current_position();
    last = (idx + 1 >= fp);
    pv = longint'(px);
    if (phase_count < DETECT_PHASE && phase_count < n) begin
      if (phase_count == 0) begin
        sum_mean[idx] = SUM_W'(pv);
        square_dev[idx] = DEV_W'(pv * pv);
      end else begin
        s = longint'(sum_mean[idx]) + pv;
        q = longint'(square_dev[idx]) + pv * pv;
        if (s > 65535) s = 65535;
        if (q > longint'(DEV_MAX)) q = longint'(DEV_MAX);
        sum_mean[idx] = SUM_W'(s);
        square_dev[idx] = DEV_W'(q);
      end
    end else if (phase_count < DETECT_PHASE) begin
      s = longint'(sum_mean[idx]);
      q = longint'(square_dev[idx]);
      m = s / longint'(n);
      if (m > 255) m = 255;
      dev = q - 2 * m * s + longint'(n) * m * m;
      if (dev < 0) dev = 0;
      if (dev > longint'(DEV_MAX)) dev = longint'(DEV_MAX);
      sum_mean[idx] = SUM_W'(m);
      square_dev[idx] = DEV_W'(dev);
    end else begin
      m = longint'(sum_mean[idx]);
      dev = longint'(square_dev[idx]);
      d = (pv > m) ? pv - m : m - pv;
      v.foreground = (d * longint'(n) * 16 > longint'(cur_weight) * dev);
      v.frame_end = last;
      expected_verdicts = {expected_verdicts, v};
    end
    if (last) begin
      next_index = 0;
      if (phase_count < DETECT_PHASE && phase_count < n) phase_count = phase_count + 1;
      else phase_count = DETECT_PHASE;
    end else begin
      next_index = idx + 1;
    end
  endtask

  function automatic int sender_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) burst_left = $urandom_range(20, 80);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] px);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel <= px;
    do @(posedge clk); while (!in_ready);
    classify_pixel(px);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FP_W-1:0] value);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      CFG_FRAME_PIXELS: cur_frame_pixels = value;
      CFG_TRAIN_FRAMES: cur_train_frames = value[N_W-1:0];
      CFG_WEIGHT_Q4:    cur_weight = value[WGT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [PIX_W-1:0] training_level(input int pos);
    int v;
    v = int'(base_level[pos]) + int'($urandom_range(0, 2 * spread[pos])) - spread[pos];
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[PIX_W-1:0];
  endfunction

  function automatic logic [PIX_W-1:0] detection_level();
    int unsigned idx;
    longint      m;
    longint      bound;
    longint      d;
    longint      v;
    int          r;
    idx = current_position();
    m = longint'(sum_mean[idx]);
    r = $urandom_range(0, 99);
    if (r < 15) return PIX_W'($urandom_range(0, 255));
    if (r < 20) return '0;
    if (r < 25) return MEAN_MAX;
    if (r < 65) begin
      bound = longint'(cur_weight) * longint'(square_dev[idx]) /
              (longint'(frames_used()) * 16);
      d = bound + longint'($urandom_range(0, 4)) - 2;
    end else begin
      d = longint'($urandom_range(0, $urandom_range(0, 64)));
    end
    if (d < 0) d = 0;
    if (d > 255) d = 255;
    v = ($urandom_range(0, 1) != 0) ? m + d : m - d;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[PIX_W-1:0];
  endfunction

  task automatic test_training();
    int r;
    for (int pos = 0; pos < TRAIN_PIXELS; pos++) begin
      base_level[pos] = $urandom_range(0, 255);
      r = $urandom_range(0, 2);
      spread[pos] = (r == 0) ? 0 : (r == 1) ? $urandom_range(1, 6) : $urandom_range(20, 120);
    end
    base_level[0] = '0;
    spread[0] = 0;
    base_level[1] = MEAN_MAX;
    spread[1] = 0;
    base_level[2] = '0;
    spread[2] = 255;
    base_level[3] = MEAN_MAX;
    spread[3] = 255;
    write_reg(CFG_FRAME_PIXELS, FP_W'(TRAIN_PIXELS));
    write_reg(CFG_TRAIN_FRAMES, '0);
    for (int pos = 0; pos < TRAIN_PIXELS; pos++) send_pixel(training_level(pos));
    wait_idle();
    write_reg(CFG_TRAIN_FRAMES, FP_W'(4));
    for (int f = 1; f < 4; f++) begin
      for (int pos = 0; pos < TRAIN_PIXELS; pos++) send_pixel(training_level(pos));
    end
  endtask

  task automatic test_model_frame();
    repeat (TRAIN_PIXELS / 2) send_pixel(PIX_W'($urandom_range(0, 255)));
    wait_idle();
    write_reg(CFG_TRAIN_FRAMES, '0);
    repeat (TRAIN_PIXELS / 2) send_pixel(PIX_W'($urandom_range(0, 255)));
    wait_idle();
    write_reg(CFG_TRAIN_FRAMES, FP_W'(4));
  endtask

  task automatic test_detection_directed();
    int m;
    for (int i = 0; i < 24; i++) begin
      m = int'(sum_mean[current_position()]);
      case (i % 5)
        0: send_pixel(PIX_W'(m));
        1: send_pixel(PIX_W'((m == 255) ? 255 : m + 1));
        2: send_pixel(PIX_W'((m == 0) ? 0 : m - 1));
        3: send_pixel('0);
        default: send_pixel(MEAN_MAX);
      endcase
    end
  endtask

  task automatic test_weight_sweep();
    for (int k = 0; k < 6; k++) begin
      wait_idle();
      case (k)
        0: write_reg(CFG_WEIGHT_Q4, FP_W'(32));
        1: write_reg(CFG_WEIGHT_Q4, '0);
        2: begin
          write_reg(CFG_WEIGHT_Q4, FP_W'(4095));
          write_reg(CFG_TRAIN_FRAMES, FP_W'(255));
        end
        3: begin
          write_reg(CFG_TRAIN_FRAMES, '0);
          write_reg(CFG_WEIGHT_Q4, FP_W'($urandom_range(0, 4095)));
        end
        default: begin
          write_reg(CFG_TRAIN_FRAMES, FP_W'($urandom_range(1, 255)));
          write_reg(CFG_WEIGHT_Q4, FP_W'($urandom_range(0, 4095)));
        end
      endcase
      repeat (160) send_pixel(detection_level());
    end
  endtask

  task automatic test_frame_resize();
    while (next_index < 12) send_pixel(detection_level());
    wait_idle();
    write_reg(CFG_FRAME_PIXELS, FP_W'(5));
    repeat (40) send_pixel(detection_level());
    wait_idle();
    write_reg(CFG_FRAME_PIXELS, '0);
    repeat (20) send_pixel(detection_level());
    wait_idle();
    write_reg(CFG_FRAME_PIXELS, '1);
    write_reg(CFG_FRAME_PIXELS, FP_W'(TRAIN_PIXELS));
    for (int k = 0; k < 4; k++) begin
      wait_idle();
      write_reg(CFG_FRAME_PIXELS, FP_W'($urandom_range(1, TRAIN_PIXELS)));
      write_reg(CFG_WEIGHT_Q4, FP_W'($urandom_range(0, 64)));
      repeat (60) send_pixel(detection_level());
    end
  endtask

  always @(posedge clk) begin
    if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else if (out_ready) begin
      out_ready <= 1'b0;
      ready_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(8, 60);
    end else begin
      out_ready <= 1'b1;
      ready_left <= ($urandom_range(0, 9) < 7) ? $urandom_range(0, 12)
                                                : $urandom_range(40, 200);
    end
  end

  always @(posedge clk) begin : check_results
    verdict_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        if (flag_errors < MAX_REPORTS)
          $display("unexpected transaction at cycle %0d: foreground=%0b frame_end=%0b",
                   cycle_count, foreground, frame_end);
        flag_errors++;
      end else begin
        want = expected_verdicts.pop_front();
        if (foreground !== want.foreground || frame_end !== want.frame_end) begin
          if (flag_errors < MAX_REPORTS)
            $display("mismatch at cycle %0d: expected foreground=%0b frame_end=%0b, %s%0b %s%0b",
                     cycle_count, want.foreground, want.frame_end,
                     "got foreground=", foreground, "frame_end=", frame_end);
          flag_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_training();
    test_model_frame();
    test_detection_directed();
    test_weight_sweep();
    test_frame_resize();
    wait_idle();
    if (flag_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
